// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the virtual timer multiplexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/vtm_pkg.sv
// Types and constants of the virtual timer multiplexer.
package vtm_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int TIME_W    = 32;
  localparam int ID_W      = 3;
  localparam int EV_W      = 3;
  localparam int OP_W      = 2;
  localparam int MAX_SLOTS = 1 << ID_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_STARTED   = 3'd0,
    EV_NOFREE    = 3'd1,
    EV_FIRED     = 3'd2,
    EV_CANCELLED = 3'd3,
    EV_IDLE      = 3'd4
  } event_e;

endpackage

// File: rtl/vtm_if.sv
// Handshake channels of the virtual timer multiplexer: request words in, event words out.
interface vtm_in_if import vtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] duration;
  logic              repeat_req;
  logic [ID_W-1:0]   cancel_id;

  modport source (output valid, op, duration, repeat_req, cancel_id, input ready);
  modport sink   (input valid, op, duration, repeat_req, cancel_id, output ready);
endinterface

interface vtm_out_if import vtm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [EV_W-1:0] event_res;
  logic [ID_W-1:0] slot_id;
  logic            last;

  modport source (output valid, event_res, slot_id, last, input ready);
  modport sink   (input valid, event_res, slot_id, last, output ready);
endinterface

// File: rtl/virtual_timer_multiplexer.sv
// Virtual timer multiplexer: one microsecond counter shared by up to eight slot timers.
//
//   channel | direction | modport | word
//   in_i    | input     | sink    | op, duration, repeat_req, cancel_id
//   out_o   | output    | source  | event_res, slot_id, last
//
// A start or cancel word is accepted in the idle state and carried out in the execute state,
// in which the shared 32-bit adder forms now + duration and the free-slot search picks a slot.
// A tick word passes through the execute and scan states and, if any slot fires, the emit state:
// the same adder increments the time, then one slot per cycle is compared and, if due and periodic,
// reloaded, then, while out_o does not stall, one fired word per cycle leaves through the output register.
// A stall on out_o holds the sequencer in the execute or emit state; the input is ready only when idle.
// Reset clears the time and all active and periodic flags; deadlines and periods are
// written when a slot is started and need no clearing.
`include "assert_macros.svh"

module virtual_timer_multiplexer import vtm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  vtm_in_if.sink    in_i,
  vtm_out_if.source out_o
);

  // Slot ids are three bits wide, so at most eight slots are usable.
  localparam int NSLOT = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NSLOT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] dur_q;
  logic              rep_q;
  logic [ID_W-1:0]   cid_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  idx_q;
  logic [NSLOT-1:0]  due_q;
  logic [NSLOT-1:0]  act_q;
  logic [NSLOT-1:0]  per_q;
  logic [TIME_W-1:0] dl_q [NSLOT];
  logic [TIME_W-1:0] pd_q [NSLOT];

  logic            ov_q;
  logic [EV_W-1:0] oev_q;
  logic [ID_W-1:0] oid_q;
  logic            olast_q;

  logic              acc;
  logic              out_free;
  logic [TIME_W-1:0] add_a;
  logic [TIME_W-1:0] add_b;
  logic [TIME_W-1:0] add_sum;
  logic              hit;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  due_idx;
  logic [NSLOT-1:0]  due_rest;
  logic [IDX_W-1:0]  cid_idx;
  logic              cid_live;
  logic              start_go;
  logic              dl_we;
  logic [IDX_W-1:0]  dl_wa;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign acc             = in_i.valid && (state_q == ST_IDLE);
  assign out_free        = !ov_q || out_o.ready;
  assign out_o.valid     = ov_q;
  assign out_o.event_res = oev_q;
  assign out_o.slot_id   = oid_q;
  assign out_o.last      = olast_q;

  // The one adder: time increment, start deadline, and periodic reload during the scan.
  always_comb begin
    add_a = now_q;
    add_b = dur_q;
    case (state_q)
      ST_EXEC: begin
        add_a = now_q;
        add_b = (op_q == OP_TICK) ? TIME_W'(1) : dur_q;
      end
      ST_SCAN: begin
        add_a = dl_q[idx_q];
        add_b = pd_q[idx_q];
      end
      default: begin
        add_a = now_q;
        add_b = dur_q;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  // Compare unit: the slot under the scan index is due at the new time.
  assign hit = act_q[idx_q] && (dl_q[idx_q] == now_q);

  // Lowest free slot, and lowest due slot with the mask of those still to report.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    due_idx    = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (due_q[i]) begin
        due_idx = IDX_W'(i);
      end
    end
    due_rest          = due_q;
    due_rest[due_idx] = 1'b0;
  end

  assign cid_idx  = cid_q[IDX_W-1:0];
  assign cid_live = (32'(cid_q) < NSLOT) && act_q[cid_idx];

  assign start_go = (state_q == ST_EXEC) && (op_q == OP_START) && out_free && free_found;
  assign dl_we    = start_go || ((state_q == ST_SCAN) && hit && per_q[idx_q]);
  assign dl_wa    = (state_q == ST_SCAN) ? idx_q : free_idx;

  // Request word and slot tables; written before they are read, so no reset.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q  <= in_i.op;
      dur_q <= (in_i.duration == '0) ? TIME_W'(1) : in_i.duration;
      rep_q <= in_i.repeat_req;
      cid_q <= in_i.cancel_id;
    end
    if (dl_we) begin
      dl_q[dl_wa] <= add_sum;
    end
    if (start_go) begin
      pd_q[free_idx] <= dur_q;
    end
  end

  // Sequencer, slot flags and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      now_q   <= '0;
      idx_q   <= '0;
      due_q   <= '0;
      act_q   <= '0;
      per_q   <= '0;
      ov_q    <= 1'b0;
      oev_q   <= '0;
      oid_q   <= '0;
      olast_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op_q)
            OP_TICK: begin
              now_q   <= add_sum;
              idx_q   <= '0;
              due_q   <= '0;
              state_q <= ST_SCAN;
            end
            OP_START: begin
              if (out_free) begin
                ov_q    <= 1'b1;
                olast_q <= 1'b1;
                if (free_found) begin
                  act_q[free_idx] <= 1'b1;
                  per_q[free_idx] <= rep_q;
                  oev_q <= EV_STARTED;
                  oid_q <= ID_W'(free_idx);
                end else begin
                  oev_q <= EV_NOFREE;
                  oid_q <= '0;
                end
                state_q <= ST_IDLE;
              end
            end
            OP_CANCEL: begin
              if (out_free) begin
                ov_q    <= 1'b1;
                olast_q <= 1'b1;
                oid_q   <= cid_q;
                if (cid_live) begin
                  act_q[cid_idx] <= 1'b0;
                  per_q[cid_idx] <= 1'b0;
                  oev_q <= EV_CANCELLED;
                end else begin
                  oev_q <= EV_IDLE;
                end
                state_q <= ST_IDLE;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SCAN: begin
          if (hit) begin
            due_q[idx_q] <= 1'b1;
            if (!per_q[idx_q]) begin
              act_q[idx_q] <= 1'b0;
            end
          end
          if (idx_q == IDX_LAST) begin
            state_q <= (hit || (due_q != '0)) ? ST_EMIT : ST_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            oev_q   <= EV_FIRED;
            oid_q   <= ID_W'(due_idx);
            olast_q <= (due_rest == '0);
            due_q   <= due_rest;
            if (due_rest == '0) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The final fired word of a tick hands control back to the idle state.
  `ASSERT_PROP(a_emit_last_idle, clk_i, rst_ni, (state_q == ST_EMIT && out_free && due_rest == '0) |=> (state_q == ST_IDLE), "last fired word did not end the tick")
  // An accepted tick advances the time by exactly one.
  `ASSERT_PROP(a_tick_advance, clk_i, rst_ni, (acc && in_i.op == OP_TICK) |=> ##1 (now_q == $past(now_q, 2) + TIME_W'(1)), "tick did not advance time by one")
  // No due slot is left over once the sequencer is idle.
  `ASSERT_NEVER(a_idle_due_clear, clk_i, rst_ni, (state_q == ST_IDLE && due_q != '0), "due mask not empty while idle")

endmodule

// File: bench/tb_virtual_timer_multiplexer.sv
// Self-checking testbench of the virtual timer multiplexer: directed and random request words.
module tb_virtual_timer_multiplexer import vtm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Only slots 0 to 7 can be named, because slot ids are three bits wide.
  localparam int NSLOT = (SLOTS_DEF < MAX_SLOTS) ? SLOTS_DEF : MAX_SLOTS;

  // The fourth op code has no meaning; the block must swallow such words silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // No accepted word on either side for this many cycles means the block has hung.
  // The longest honest quiet spell is the receiver hold-off plus a tick and the longest
  // random gaps, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 3000;

  // Cycles allowed after the last expected event word for stray words to show up.
  localparam int DRAIN_CYCLES = 40;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] duration;
    logic              repeat_req;
    logic [ID_W-1:0]   cancel_id;
  } request_t;

  typedef struct packed {
    event_e          ev;
    logic [ID_W-1:0] id;
    logic            last;
  } event_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  vtm_in_if  in_ch ();
  vtm_out_if out_ch ();

  virtual_timer_multiplexer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timer state, updated as each request word is accepted.
  logic [TIME_W-1:0] cur_time;
  logic [TIME_W-1:0] slot_deadline [NSLOT];
  logic [TIME_W-1:0] slot_period   [NSLOT];
  logic              slot_periodic [NSLOT];
  logic              slot_busy     [NSLOT];

  // Event words still owed by the block, oldest first.
  event_word_t pending_events [$];

  int  mismatches   = 0;
  int  idle_cycles  = 0;
  int  rx_hold_len  = 0;   // set by a test to make the receiver hold off for a long spell
  bit  quiet        = 1'b0; // while set, neither side inserts gaps

  // Most gaps are short, a few are long, and half of the time there is none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advances the shadow state by one request word and queues the event words it causes.
  function automatic void predict_events(input request_t w);
    event_word_t       evs [$];
    event_word_t       ew;
    logic [TIME_W-1:0] span;
    int                free_slot;
    int                i;
    free_slot = -1;
    // A zero duration behaves as one microsecond.
    span = (w.duration == '0) ? TIME_W'(1) : w.duration;
    case (w.op)
      OP_TICK: begin
        cur_time = cur_time + 1;
        // Every slot due on this tick fires, lowest slot first.
        for (i = 0; i < NSLOT; i++) begin
          if (slot_busy[i] && slot_deadline[i] == cur_time) begin
            ew = '{EV_FIRED, ID_W'(i), 1'b0};
            evs.push_back(ew);
            if (slot_periodic[i]) begin
              slot_deadline[i] = slot_deadline[i] + slot_period[i];
            end else begin
              slot_busy[i] = 1'b0;
            end
          end
        end
      end
      OP_START: begin
        for (i = NSLOT - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          ew = '{EV_NOFREE, '0, 1'b0};
        end else begin
          slot_busy[free_slot]     = 1'b1;
          slot_periodic[free_slot] = w.repeat_req;
          slot_period[free_slot]   = span;
          slot_deadline[free_slot] = cur_time + span;
          ew = '{EV_STARTED, ID_W'(free_slot), 1'b0};
        end
        evs.push_back(ew);
      end
      OP_CANCEL: begin
        if (int'(w.cancel_id) < NSLOT && slot_busy[w.cancel_id]) begin
          slot_busy[w.cancel_id]     = 1'b0;
          slot_periodic[w.cancel_id] = 1'b0;
          ew = '{EV_CANCELLED, w.cancel_id, 1'b0};
        end else begin
          ew = '{EV_IDLE, w.cancel_id, 1'b0};
        end
        evs.push_back(ew);
      end
      default: begin
        // The unused op code changes nothing and produces no event word.
      end
    endcase
    for (i = 0; i < evs.size(); i++) begin
      ew = evs[i];
      ew.last = (i == evs.size() - 1);
      pending_events.push_back(ew);
    end
  endfunction

  // Offers one request word after a random gap and waits until the block takes it.
  // Valid is left high on acceptance, so that a word sent straight after needs no
  // second assignment to valid in the same time step.
  task automatic send_word(input request_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= w.op;
    in_ch.duration   <= w.duration;
    in_ch.repeat_req <= w.repeat_req;
    in_ch.cancel_id  <= w.cancel_id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_events(w);
  endtask

  function automatic request_t make_word(input logic [OP_W-1:0] op,
                                         input logic [TIME_W-1:0] duration,
                                         input logic repeat_req,
                                         input logic [ID_W-1:0] cancel_id);
    request_t w;
    w.op         = op;
    w.duration   = duration;
    w.repeat_req = repeat_req;
    w.cancel_id  = cancel_id;
    return w;
  endfunction

  // Random request word. Durations are mostly short, so that timers really fire within
  // the run; now and then a full 32-bit value is used so that every bit gets exercised.
  function automatic request_t random_word(input int tick_pct, input int start_pct);
    request_t w;
    int       r;
    w.duration   = $urandom;
    w.repeat_req = 1'($urandom_range(0, 1));
    w.cancel_id  = ID_W'($urandom_range(0, MAX_SLOTS - 1));
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      w.op = OP_TICK;
    end else if (r < tick_pct + start_pct) begin
      w.op = OP_START;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        w.duration = $urandom_range(0, 12);
      end else if (r < 85) begin
        w.duration = $urandom_range(13, 200);
      end
    end else if (r < 96) begin
      w.op = OP_CANCEL;
    end else begin
      w.op = OP_UNUSED;
    end
    return w;
  endfunction

  // Zero duration, the largest duration, a cancel of a live slot and of an idle slot, a tick
  // with nothing due and a word with the unused op code, every field at its ones value.
  task automatic test_duration_extremes();
    send_word(make_word(OP_START, '0, 1'b0, '0));
    send_word(make_word(OP_TICK, '0, 1'b0, '0));
    send_word(make_word(OP_START, '1, 1'b1, '1));
    send_word(make_word(OP_CANCEL, '1, 1'b1, '0));
    send_word(make_word(OP_CANCEL, '0, 1'b0, 3'd5));
    send_word(make_word(OP_TICK, '1, 1'b1, '1));
    send_word(make_word(OP_UNUSED, '1, 1'b1, '1));
  endtask

  // Fills every slot with the same deadline, overflows the table, lets all slots fire on
  // one tick (odd slots periodic, so they reload) and then cancels slot by slot, which
  // hits both live and already freed slots.
  task automatic test_full_table();
    int i;
    for (i = 0; i < NSLOT; i++) begin
      send_word(make_word(OP_START, TIME_W'(2), i[0], '0));
    end
    send_word(make_word(OP_START, TIME_W'(2), 1'b0, '0));
    send_word(make_word(OP_TICK, '0, 1'b0, '0));
    send_word(make_word(OP_TICK, '0, 1'b0, '0));
    for (i = 0; i < MAX_SLOTS; i++) begin
      send_word(make_word(OP_CANCEL, '0, 1'b0, ID_W'(i)));
    end
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_word(random_word(50, 28));
  endtask

  // The receiver stops taking event words for a long spell while ticks and short timers
  // keep coming, so the output backs up and the block has to stall its input.
  task automatic test_output_backpressure();
    rx_hold_len = HOLD_OFF_CYCLES;
    repeat (40) send_word(random_word(60, 30));
  endtask

  // Back-to-back words with the receiver always ready.
  task automatic test_no_gaps();
    quiet = 1'b1;
    repeat (50) send_word(random_word(50, 28));
    quiet = 1'b0;
  endtask

  // Stops offering words and waits until every owed event word has come out.
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Event word checker: each accepted word is matched against the oldest expectation.
  always @(posedge clk) begin
    event_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event word ev=%0d id=%0d last=%0d",
                                  out_ch.event_res, out_ch.slot_id, out_ch.last));
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_res !== want.ev || out_ch.slot_id !== want.id ||
            out_ch.last !== want.last) begin
          report_mismatch($sformatf("expected ev=%0d (%s) id=%0d last=%0d, got ev=%0d id=%0d last=%0d",
                                    want.ev, want.ev.name(), want.id, want.last,
                                    out_ch.event_res, out_ch.slot_id, out_ch.last));
        end
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off when a test asks for one. Each pass
  // assigns ready at most once per time step, as every assignment is followed by a wait on the clock.
  initial begin : event_receiver
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: a long spell in which neither channel moves a word ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word accepted for %0d cycles, %0d event words owed",
                 WATCHDOG_LIMIT, pending_events.size());
        $display("FAIL virtual_timer_multiplexer");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : main_sequence
    int i;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TICK;
    in_ch.duration   <= '0;
    in_ch.repeat_req <= 1'b0;
    in_ch.cancel_id  <= '0;
    // The shadow state starts as the block leaves reset: time zero and no live timers.
    // Deadlines and periods are only ever read for live slots, so their value is moot.
    cur_time = '0;
    for (i = 0; i < NSLOT; i++) begin
      slot_deadline[i] = '0;
      slot_period[i]   = '0;
      slot_periodic[i] = 1'b0;
      slot_busy[i]     = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_duration_extremes();
    test_full_table();
    test_random_traffic(260);
    test_output_backpressure();
    test_no_gaps();
    drain_events();

    if (mismatches == 0) begin
      $display("PASS virtual_timer_multiplexer");
    end else begin
      $display("FAIL virtual_timer_multiplexer");
    end
    $finish;
  end

endmodule
